[hw/rtl/sha1_stream_hasher_assert.svh]
// ----------------------------------------------------------------------------
// sha1 stream hasher assertion macros
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SHA1SH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha1 stream hasher check failed");
// next-cycle implication
`define SHA1SH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha1 stream hasher check failed");
`else
`define SHA1SH_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SHA1SH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/sha1sh_pkg.sv]
// ----------------------------------------------------------------------------
// sha1 stream hasher package
// Sequencer states and SHA-1 constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1sh_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam int CHAIN_WORDS = 5;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

   localparam logic [6:0] LAST_ROUND  = 7'd79;
   localparam logic [6:0] PHASE1_START = 7'd20;
   localparam logic [6:0] PHASE2_START = 7'd40;
   localparam logic [6:0] PHASE3_START = 7'd60;

   localparam logic [31:0] INIT_CHAIN [CHAIN_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] K_PHASE0 = 32'h5a827999;
   localparam logic [31:0] K_PHASE1 = 32'h6ed9eba1;
   localparam logic [31:0] K_PHASE2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_PHASE3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LAST_FILL = 6'd63;
   // bytes 56..63 of a block hold the bit count
   localparam logic [2:0] LENGTH_OCTET = 3'b111;

endpackage

[hw/rtl/sha1sh_req_if.sv]
// ----------------------------------------------------------------------------
// sha1 stream hasher request channel
// Valid/ready channel carrying one message byte and an end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

[hw/rtl/sha1sh_rsp_if.sv]
// ----------------------------------------------------------------------------
// sha1 stream hasher response channel
// Valid/ready channel carrying one 32-bit digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

[hw/rtl/sha1_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha1 stream hasher
// Byte-stream SHA-1: one shared round unit runs the 80 rounds of each block.
// ----------------------------------------------------------------------------
// channel   dir  payload                                  request moves
// req_bus   in   data_byte, byte_present, end_of_message  one byte and/or end
// rsp_bus   out  digest_word, word_index, last_word       one digest word
//
// a request is taken while req_bus.ready is high; one that completes a block then
// runs the rounds on the shared round unit and one chain add before the next request.
// end of message: the padding bytes (9..72) are written, each padded block is hashed,
// then the five digest words are returned; req_bus.ready is low during all of this.
// reset is synchronous and needs no clearing pass; a stalled response holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha1_stream_hasher_assert.svh"

module sha1_stream_hasher (
   input logic          clock,
   input logic          reset,
   sha1sh_req_if.sink   req_bus,
   sha1sh_rsp_if.source rsp_bus
);
   import sha1sh_pkg::*;

   state_type state_ff, state_in;

   // 64-byte block as a shift line; also the 16-word message schedule window
   logic [511:0] win_ff, win_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  bytes_ff, bytes_in;
   logic [31:0]  chain_ff [CHAIN_WORDS];
   logic [31:0]  chain_in [CHAIN_WORDS];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [6:0]   round_ff, round_in;
   logic [2:0]   out_idx_ff, out_idx_in;
   logic         end_pend_ff, end_pend_in;
   logic         mark_done_ff, mark_done_in;
   logic         need_wrap_ff, need_wrap_in;
   logic         len_done_ff, len_done_in;

   logic        req_take;
   logic        rsp_take;
   logic        byte_wr;
   logic [7:0]  byte_val;
   logic [7:0]  pad_byte;
   logic        block_full;
   logic        len_phase;
   logic [63:0] len_bits;
   logic [63:0] len_shifted;
   logic [31:0] w0, w2, w8, w13, w_mix, w_next;
   logic [31:0] f_val, k_val, round_sum;
   logic        out_done;

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_OUT:  rsp_bus.valid = 1'b1;
         default: begin
            req_bus.ready = 1'b0;
            rsp_bus.valid = 1'b0;
         end
      endcase
   end

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;
   assign out_done = rsp_take && (out_idx_ff == LAST_WORD_INDEX);

   assign rsp_bus.digest_word = chain_ff[out_idx_ff];
   assign rsp_bus.word_index  = out_idx_ff;
   assign rsp_bus.last_word   = (out_idx_ff == LAST_WORD_INDEX);

   // padding byte: mark, zeros, then the big-endian bit count
   assign len_bits    = {bytes_ff, 3'b000};
   assign len_shifted = len_bits >> {~fill_ff[2:0], 3'b000};
   assign len_phase   = mark_done_ff && !need_wrap_ff && (fill_ff[5:3] == LENGTH_OCTET);

   always_comb begin
      if (!mark_done_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_phase) begin
         pad_byte = len_shifted[7:0];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      byte_wr  = 1'b0;
      byte_val = req_bus.data_byte;
      case (state_ff)
         ST_IDLE: byte_wr = req_take && req_bus.byte_present;
         ST_PAD: begin
            byte_wr  = 1'b1;
            byte_val = pad_byte;
         end
         default: byte_wr = 1'b0;
      endcase
   end

   assign block_full = byte_wr && (fill_ff == LAST_FILL);

   // ------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (block_full) begin
                  state_in = ST_ROUND;
               end else if (req_bus.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (len_done_ff) begin
               state_in = ST_OUT;
            end else if (end_pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (out_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------ round unit
   assign w0  = win_ff[511:480];
   assign w2  = win_ff[447:416];
   assign w8  = win_ff[255:224];
   assign w13 = win_ff[95:64];
   assign w_mix  = w13 ^ w8 ^ w2 ^ w0;
   assign w_next = {w_mix[30:0], w_mix[31]};

   always_comb begin
      if (round_ff < PHASE1_START) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_PHASE0;
      end else if (round_ff < PHASE2_START) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_PHASE1;
      end else if (round_ff < PHASE3_START) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_PHASE2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_PHASE3;
      end
   end

   assign round_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w0;

   // -------------------------------------------------------------- datapath
   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      bytes_in     = bytes_ff;
      chain_in     = chain_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      end_pend_in  = end_pend_ff;
      mark_done_in = mark_done_ff;
      need_wrap_in = need_wrap_ff;
      len_done_in  = len_done_ff;

      if (byte_wr) begin
         win_in  = {win_ff[503:0], byte_val};
         fill_in = fill_ff + 6'd1;
      end
      if (req_take && req_bus.byte_present) begin
         bytes_in = bytes_ff + 61'd1;
      end
      if (req_take && req_bus.end_of_message) begin
         end_pend_in = 1'b1;
      end

      if (state_ff == ST_PAD) begin
         if (!mark_done_ff) begin
            mark_done_in = 1'b1;
            // mark lands in the length field, so another block is needed
            need_wrap_in = (fill_ff[5:3] == LENGTH_OCTET);
         end
         if (len_phase && (fill_ff == LAST_FILL)) begin
            len_done_in = 1'b1;
         end
      end

      // seed the working variables on entry to the rounds
      if ((state_ff != ST_ROUND) && (state_in == ST_ROUND)) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = 7'd0;
      end

      if (state_ff == ST_ROUND) begin
         win_in   = {win_ff[479:0], w_next};
         a_in     = round_sum;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = round_ff + 7'd1;
      end

      if (state_ff == ST_ADD) begin
         chain_in[0]  = chain_ff[0] + a_ff;
         chain_in[1]  = chain_ff[1] + b_ff;
         chain_in[2]  = chain_ff[2] + c_ff;
         chain_in[3]  = chain_ff[3] + d_ff;
         chain_in[4]  = chain_ff[4] + e_ff;
         need_wrap_in = 1'b0;
      end

      if (rsp_take) begin
         out_idx_in = out_idx_ff + 3'd1;
      end
      if (out_done) begin
         chain_in     = INIT_CHAIN;
         fill_in      = 6'd0;
         bytes_in     = 61'd0;
         out_idx_in   = 3'd0;
         end_pend_in  = 1'b0;
         mark_done_in = 1'b0;
         need_wrap_in = 1'b0;
         len_done_in  = 1'b0;
      end
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 6'd0;
         bytes_ff     <= 61'd0;
         chain_ff     <= INIT_CHAIN;
         round_ff     <= 7'd0;
         out_idx_ff   <= 3'd0;
         end_pend_ff  <= 1'b0;
         mark_done_ff <= 1'b0;
         need_wrap_ff <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bytes_ff     <= bytes_in;
         chain_ff     <= chain_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         end_pend_ff  <= end_pend_in;
         mark_done_ff <= mark_done_in;
         need_wrap_ff <= need_wrap_in;
         len_done_ff  <= len_done_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   // ------------------------------------------------------------ assertions
   `SHA1SH_ASSERT_NOW(a_no_overlap, clock, reset, 1'b1, !(req_bus.ready && rsp_bus.valid))
   `SHA1SH_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_take && rsp_bus.last_word, req_bus.ready)
   `SHA1SH_ASSERT_NEXT(a_fill_held, clock, reset, state_ff == ST_ROUND, $stable(fill_ff))
   `SHA1SH_ASSERT_NOW(a_round_range, clock, reset, state_ff == ST_ROUND, round_ff <= LAST_ROUND)

endmodule

[bench/tb_sha1_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 stream hasher testbench
// Sends byte and end-of-message requests into the hasher. An independent
// SHA-1 model predicts each digest, and every word that comes back is checked
// in order against it. The run goes through several idle and stall phases and
// includes one long back-pressure hold on the digest side.
// ----------------------------------------------------------------------------

module tb_sha1_stream_hasher;

   localparam int unsigned RUN_LIMIT   = 400000;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int unsigned TAIL_CYCLES = 300;
   localparam int unsigned PHASES      = 5;
   localparam int unsigned PHASE_ITEMS = 24;
   localparam int unsigned PHASE_MSGS  = 2;

   // last phase runs without idling but starts with the long digest hold
   localparam int unsigned SEND_IDLE_PCT  [PHASES] = '{0, 79, 0, 24, 0};
   localparam int unsigned SINK_STALL_PCT [PHASES] = '{0, 0, 79, 24, 0};

   // lengths around the padding and block limits
   localparam int unsigned BOUNDARY_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   class sha1_digest_board;
      logic [31:0]     chain [5];
      logic [7:0]      block [64];
      int unsigned     fill;
      logic [60:0]     msg_len_bytes;
      digest_word_type pending [$];
      int unsigned     errors;
      int unsigned     words_checked;

      function new();
         errors = 0;
         words_checked = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h67452301;
         chain[1] = 32'hefcdab89;
         chain[2] = 32'h98badcfe;
         chain[3] = 32'h10325476;
         chain[4] = 32'hc3d2e1f0;
         fill = 0;
         msg_len_bytes = '0;
      endfunction

      // one byte into the block; a full block is folded into the chain
      function void absorb_byte(logic [7:0] value);
         logic [31:0] w [80];
         logic [31:0] a, b, c, d, e, f, k, sum;
         block[fill] = value;
         fill++;
         if (fill < 64) return;
         fill = 0;
         for (int t = 0; t < 16; t++) begin
            w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
         end
         for (int t = 16; t < 80; t++) begin
            sum = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
            w[t] = {sum[30:0], sum[31]};
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5a827999;
            end else if (t < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ed9eba1;
            end else if (t < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8f1bbcdc;
            end else begin
               f = b ^ c ^ d;
               k = 32'hca62c1d6;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + w[t];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void note_request(logic [7:0] data, logic present, logic closes);
         logic [63:0]     msg_len_bits;
         digest_word_type entry;
         if (present) begin
            absorb_byte(data);
            msg_len_bytes++;
         end
         if (!closes) return;
         // byte count wraps at 61 bits, so the bit count wraps at 64
         msg_len_bits = {msg_len_bytes, 3'b000};
         absorb_byte(8'h80);
         while (fill != 56) absorb_byte(8'h00);
         for (int i = 7; i >= 0; i--) absorb_byte(msg_len_bits[8*i +: 8]);
         for (int i = 0; i < 5; i++) begin
            entry.word  = chain[i];
            entry.index = 3'(i);
            entry.last  = (i == 4);
            pending.push_back(entry);
         end
         restart();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_word_type want;
         if (pending.size() == 0) begin
            report($sformatf("digest word %h index %0d with no digest outstanding",
                             word, index));
            return;
         end
         want = pending.pop_front();
         words_checked++;
         if (word !== want.word)
            report($sformatf("word %0d: got %h, want %h", want.index, word, want.word));
         if (index !== want.index)
            report($sformatf("word index: got %0d, want %0d", index, want.index));
         if (last !== want.last)
            report($sformatf("last flag on word %0d: got %b, want %b",
                             want.index, last, want.last));
      endtask

      task check_leftover();
         if (pending.size() != 0)
            report($sformatf("%0d digest words never returned", pending.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   sha1sh_req_if req_bus ();
   sha1sh_rsp_if rsp_bus ();

   sha1_stream_hasher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sha1_digest_board board;

   int unsigned sender_idle_pct = 0;
   int unsigned sink_stall_pct  = 0;
   bit          hold_go         = 1'b0;
   int unsigned items_sent      = 0;
   int unsigned messages_sent   = 0;
   int unsigned cycle_count     = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // digest side: check accepted words, drive ready with random stalls
   initial begin
      int unsigned hold_left;
      bit          hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            board.check_word(rsp_bus.digest_word, rsp_bus.word_index, rsp_bus.last_word);
         end
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // valid stays high from one request to the next unless an idle gap is drawn
   task automatic send_item(input logic [7:0] data, input logic present,
                            input logic closes);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.byte_present   <= present;
      req_bus.end_of_message <= closes;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(data, present, closes);
      if (present || closes) items_sent++;
      if (closes) messages_sent++;
   endtask

   initial begin
      int unsigned phase_items, phase_msgs, len, n;
      bit          joined;
      board = new();
      reset <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= 8'h00;
      req_bus.byte_present   <= 1'b0;
      req_bus.end_of_message <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty message
      send_item(8'h00, 1'b0, 1'b1);
      // "abc", last byte closes the message in the same request
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // requests with neither flag, data must be ignored
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      // byte extremes, then an end request whose data byte is not present
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'ha5, 1'b0, 1'b1);
      // single byte equal to the pad marker
      send_item(8'h80, 1'b1, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle_pct = SEND_IDLE_PCT[phase];
         sink_stall_pct <= SINK_STALL_PCT[phase];
         if (phase == PHASES - 1) hold_go <= 1'b1;
         phase_items = items_sent;
         phase_msgs = messages_sent;
         while (items_sent - phase_items < PHASE_ITEMS ||
                messages_sent - phase_msgs < PHASE_MSGS) begin
            if ($urandom_range(3) != 0) len = $urandom_range(12);
            else len = BOUNDARY_LEN[$urandom_range(7)];
            joined = (len > 0) && ($urandom_range(1) == 1);
            n = 0;
            while (n < len) begin
               if ($urandom_range(99) < 8) begin
                  send_item(8'($urandom), 1'b0, 1'b0);
               end else begin
                  send_item(8'($urandom), 1'b1, joined && (n == len - 1));
                  n++;
               end
            end
            if (!joined) send_item(8'($urandom), 1'b0, 1'b1);
         end
      end
      req_bus.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      board.check_leftover();

      $display("hashed %0d messages from %0d byte/end requests over %0d load phases",
               messages_sent, items_sent, PHASES);
      $display("compared %0d digest words, %0d mismatches",
               board.words_checked, board.errors);
      if (board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_req_if.sv
hw/rtl/sha1sh_rsp_if.sv
hw/rtl/sha1_stream_hasher.sv
bench/tb_sha1_stream_hasher.sv
